// ===== hw/rtl/humidity_temp_frame_to_display_defines.svh =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_to_display assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_TO_DISPLAY_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_TO_DISPLAY_DEFINES_SVH

// same-cycle implication
`define HTFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// transaction types, codes and segment patterns of the sensor display block
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_BUS_ERR = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  localparam logic [1:0] VIEW_CURRENT = 2'd0;
  localparam logic [1:0] VIEW_HIGHEST = 2'd1;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_MINUS = 8'hDF;
  localparam logic [3:0] DIGIT_MINUS = 4'd10;

  localparam logic signed [11:0] TEMP_OFFSET    = 12'sd500;
  localparam logic signed [11:0] TEMP_RST_HIGH  = -12'sd500;
  localparam logic signed [11:0] TEMP_RST_LOW   = 12'sd1500;
  localparam logic signed [11:0] TEMP_SHOW_MAX  = 12'sd999;
  localparam logic signed [11:0] TEMP_SHOW_MIN  = -12'sd99;
  localparam logic [9:0]         HUM_RST_HIGH   = 10'd0;
  localparam logic [9:0]         HUM_RST_LOW    = 10'd1000;
  localparam logic [9:0]         HUM_SHOW_MAX   = 10'd999;
  localparam logic [10:0]        TEMP_SCALE     = 11'd2000;
  localparam logic [9:0]         HUM_SCALE      = 10'd1000;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] status_byte;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [1:0] view_select;
  } htfd_in_t;

  typedef struct packed {
    logic [7:0] digit0_segments;
    logic [7:0] digit1_segments;
    logic [7:0] digit2_segments;
    logic [7:0] digit3_segments;
    logic [7:0] digit4_segments;
    logic [7:0] digit5_segments;
    logic       sensor_fault;
  } htfd_out_t;

  // active low, bit order A B G F E C D dp
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:        s = 8'h21;
      4'd1:        s = 8'hBB;
      4'd2:        s = 8'h15;
      4'd3:        s = 8'h19;
      4'd4:        s = 8'h8B;
      4'd5:        s = 8'h49;
      4'd6:        s = 8'h41;
      4'd7:        s = 8'h2B;
      4'd8:        s = 8'h01;
      4'd9:        s = 8'h09;
      DIGIT_MINUS: s = SEG_MINUS;
      default:     s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_to_display.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_to_display
// sensor reply decode, min/max tracking and six-digit seven-segment formatting
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carries one transaction per operation: a sensor
//   frame, a bus failure report, a clear of the extremes or a plain refresh.
//   out_valid/out_stall/out_data returns exactly one display transaction for
//   each input, in order, with six active-low digit patterns and the fault bit.
//   three register stages: input register, decode and scaling stage (min/max
//   state updates here), format stage; out_valid and out_data come straight
//   from the format stage register. throughput is one transaction per cycle
//   while out_stall is low; the scaling multiply and the digit split sit in
//   separate stages.
//   each stage advances when the one after it is empty or moving, so bubbles
//   fill up while out_stall is high and in_stall rises only when all three
//   stages hold data.
//   reset empties the pipeline, zeroes the current values, returns the
//   extremes to their cleared values and sets the fault flag, so the display
//   reads blank with sensor_fault set until a good frame arrives.
// ----------------------------------------------------------------------------
module humidity_temp_frame_to_display
  import htfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  htfd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output htfd_out_t out_data
);

  logic      in_valid_r;
  htfd_in_t  in_data_r;
  logic      mid_valid_r;
  logic      mid_fault_r;
  logic signed [11:0] mid_temp_r;
  logic [9:0] mid_hum_r;
  logic      out_valid_r;
  htfd_out_t out_data_r;

  logic signed [11:0] cur_temp_r, cur_temp_nxt;
  logic [9:0]         cur_hum_r, cur_hum_nxt;
  logic signed [11:0] hi_temp_r, hi_temp_nxt;
  logic signed [11:0] lo_temp_r, lo_temp_nxt;
  logic [9:0]         hi_hum_r, hi_hum_nxt;
  logic [9:0]         lo_hum_r, lo_hum_nxt;
  logic               fault_r, fault_nxt;

  logic ready_out, ready_mid, ready_in;
  logic mid_load;

  logic [19:0] raw_hum, raw_temp;
  logic [30:0] prod_temp;
  logic [29:0] prod_hum;
  logic signed [11:0] new_temp;
  logic [9:0]  new_hum;
  logic        good_frame;
  logic signed [11:0] sel_temp;
  logic [9:0]  sel_hum;

  logic        temp_blank, temp_neg;
  logic [11:0] temp_abs;
  logic [3:0]  t_hund, t_tens, t_units, t_qt, t_rem;
  logic [3:0]  h_hund, h_tens, h_units;
  htfd_out_t   fmt;

  assign ready_out = !out_valid_r || !out_stall;
  assign ready_mid = !mid_valid_r || ready_out;
  assign ready_in  = !in_valid_r || ready_mid;
  assign in_stall  = !ready_in;
  assign mid_load  = in_valid_r && ready_mid;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (ready_in) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // stage 2: decode, scale and update state
  assign raw_hum   = {in_data_r.frame_byte1, in_data_r.frame_byte2,
                      in_data_r.frame_byte3[7:4]};
  assign raw_temp  = {in_data_r.frame_byte3[3:0], in_data_r.frame_byte4,
                      in_data_r.frame_byte5};
  assign prod_temp = {11'd0, raw_temp} * {20'd0, TEMP_SCALE};
  assign prod_hum  = {10'd0, raw_hum} * {20'd0, HUM_SCALE};
  assign new_temp  = $signed({1'b0, prod_temp[30:20]}) - TEMP_OFFSET;
  assign new_hum   = prod_hum[29:20];
  assign good_frame = !in_data_r.status_byte[7] && ((raw_hum != '0) || (raw_temp != '0));

  always_comb begin
    cur_temp_nxt = cur_temp_r;
    cur_hum_nxt  = cur_hum_r;
    hi_temp_nxt  = hi_temp_r;
    lo_temp_nxt  = lo_temp_r;
    hi_hum_nxt   = hi_hum_r;
    lo_hum_nxt   = lo_hum_r;
    fault_nxt    = fault_r;
    unique case (in_data_r.operation)
      OP_FRAME: begin
        if (good_frame) begin
          fault_nxt    = 1'b0;
          cur_temp_nxt = new_temp;
          cur_hum_nxt  = new_hum;
          if (new_temp > hi_temp_r) hi_temp_nxt = new_temp;
          if (new_temp < lo_temp_r) lo_temp_nxt = new_temp;
          if (new_hum > hi_hum_r) hi_hum_nxt = new_hum;
          if (new_hum < lo_hum_r) lo_hum_nxt = new_hum;
        end else begin
          fault_nxt = 1'b1;
        end
      end
      OP_BUS_ERR: fault_nxt = 1'b1;
      OP_CLEAR: begin
        hi_temp_nxt = TEMP_RST_HIGH;
        lo_temp_nxt = TEMP_RST_LOW;
        hi_hum_nxt  = HUM_RST_HIGH;
        lo_hum_nxt  = HUM_RST_LOW;
      end
      OP_REFRESH: ;
      default: ;
    endcase
  end

  always_comb begin
    priority if (in_data_r.view_select == VIEW_CURRENT) begin
      sel_temp = cur_temp_nxt;
      sel_hum  = cur_hum_nxt;
    end else if (in_data_r.view_select == VIEW_HIGHEST) begin
      sel_temp = hi_temp_nxt;
      sel_hum  = hi_hum_nxt;
    end else begin
      sel_temp = lo_temp_nxt;
      sel_hum  = lo_hum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_temp_r  <= '0;
      cur_hum_r   <= '0;
      hi_temp_r   <= TEMP_RST_HIGH;
      lo_temp_r   <= TEMP_RST_LOW;
      hi_hum_r    <= HUM_RST_HIGH;
      lo_hum_r    <= HUM_RST_LOW;
      fault_r     <= 1'b1;
      mid_valid_r <= 1'b0;
    end else begin
      if (mid_load) begin
        cur_temp_r <= cur_temp_nxt;
        cur_hum_r  <= cur_hum_nxt;
        hi_temp_r  <= hi_temp_nxt;
        lo_temp_r  <= lo_temp_nxt;
        hi_hum_r   <= hi_hum_nxt;
        lo_hum_r   <= lo_hum_nxt;
        fault_r    <= fault_nxt;
      end
      if (ready_mid) begin
        mid_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_load) begin
      mid_fault_r <= fault_nxt;
      mid_temp_r  <= sel_temp;
      mid_hum_r   <= sel_hum;
    end
  end

  // stage 3: digit split and segment patterns
  function automatic logic [11:0] split3(input logic [9:0] x);
    logic [17:0] p10;
    logic [15:0] p100;
    logic [6:0]  q10;
    logic [3:0]  q100;
    logic [9:0]  u;
    logic [6:0]  t;
    p10  = {8'd0, x} * 18'd205;
    p100 = {6'd0, x} * 16'd41;
    q10  = p10[17:11];
    q100 = p100[15:12];
    u    = x - {q10, 3'b000} - {2'b00, q10, 1'b0};
    t    = q10 - {q100, 3'b000} - {2'b00, q100, 1'b0};
    return {q100, t[3:0], u[3:0]};
  endfunction

  assign temp_blank = (mid_temp_r > TEMP_SHOW_MAX) || (mid_temp_r < TEMP_SHOW_MIN);
  assign temp_neg   = mid_temp_r[11];
  assign temp_abs   = temp_neg ? 12'(-mid_temp_r) : 12'(mid_temp_r);
  assign {t_hund, t_tens, t_units} = split3(temp_abs[9:0]);
  assign {h_hund, h_tens, h_units} = split3(mid_hum_r);
  // magnitude below 100: tens of the magnitude sit in t_tens, hundreds is zero
  assign t_qt  = t_tens;
  assign t_rem = t_units;

  always_comb begin
    fmt = '0;
    if (mid_fault_r) begin
      fmt.digit0_segments = SEG_BLANK;
      fmt.digit1_segments = SEG_BLANK;
      fmt.digit2_segments = SEG_BLANK;
      fmt.digit3_segments = SEG_BLANK;
      fmt.digit4_segments = SEG_BLANK;
      fmt.digit5_segments = SEG_BLANK;
      fmt.sensor_fault    = 1'b1;
    end else begin
      priority if (temp_blank) begin
        fmt.digit3_segments = SEG_BLANK;
        fmt.digit4_segments = SEG_BLANK;
        fmt.digit5_segments = SEG_BLANK;
      end else if (temp_neg) begin
        fmt.digit5_segments = SEG_MINUS;
        fmt.digit4_segments = seg_of(t_qt);
        fmt.digit3_segments = seg_of(t_rem);
      end else begin
        fmt.digit5_segments = (t_hund == '0) ? SEG_BLANK : seg_of(t_hund);
        fmt.digit4_segments = seg_of(t_tens);
        fmt.digit3_segments = seg_of(t_units);
      end
      if (mid_hum_r > HUM_SHOW_MAX) begin
        fmt.digit0_segments = SEG_BLANK;
        fmt.digit1_segments = SEG_BLANK;
        fmt.digit2_segments = SEG_BLANK;
      end else begin
        fmt.digit2_segments = (h_hund == '0) ? SEG_BLANK : seg_of(h_hund);
        fmt.digit1_segments = seg_of(h_tens);
        fmt.digit0_segments = seg_of(h_units);
      end
      fmt.sensor_fault = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_out) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && mid_valid_r) begin
      out_data_r <= fmt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/htfd_checker.sv =====
// ----------------------------------------------------------------------------
// htfd_checker
// port-level checks of the display transactions, bound to the top level
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_to_display_defines.svh"

module htfd_checker
  import htfd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input htfd_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input htfd_out_t out_data
);

  logic out_ok;

  assign out_ok  = out_valid && !out_data.sensor_fault;

  // fault shows a fully blank display
  `HTFD_ASSERT_NOW(a_fault_blank, out_valid && out_data.sensor_fault, (out_data.digit0_segments == SEG_BLANK) && (out_data.digit1_segments == SEG_BLANK) && (out_data.digit2_segments == SEG_BLANK) && (out_data.digit3_segments == SEG_BLANK) && (out_data.digit4_segments == SEG_BLANK) && (out_data.digit5_segments == SEG_BLANK), "fault transaction with lit segments")

  // a minus sign always has two digits after it
  `HTFD_ASSERT_NOW(a_minus_digits, out_ok && (out_data.digit5_segments == SEG_MINUS), (out_data.digit4_segments != SEG_BLANK) && (out_data.digit3_segments != SEG_BLANK), "minus sign without digits")

  // humidity tenths and units blank together
  `HTFD_ASSERT_NOW(a_hum_blank, out_ok, (out_data.digit0_segments == SEG_BLANK) == (out_data.digit1_segments == SEG_BLANK), "humidity digits blanked apart")

  // stalled result holds
  `HTFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled transaction changed")

  // stalled input transaction holds
  `HTFD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled input transaction changed")

endmodule

bind humidity_temp_frame_to_display htfd_checker u_htfd_checker (.*);

// ===== tb/humidity_temp_frame_to_display_tb.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_to_display_tb
// drives sensor frames and commands into the display block, tracks current
// and extreme readings in a shadow copy, and checks every six-digit display
// transaction in order, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module humidity_temp_frame_to_display_tb;
  import htfd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 8;
  localparam int DIR_ROWS     = 24;

  localparam logic [1:0] VIEW_LOWEST = 2'd2;
  localparam logic [1:0] VIEW_SPARE  = 2'd3;
  localparam logic [7:0] STATUS_BUSY = 8'h80;

  // raw temperature codes bounding the displayable range -99 .. 999
  localparam int RAW_T_SHOW_LO = 210240;
  localparam int RAW_T_SHOW_HI = 785908;

  // digit glyphs 9 .. 0, digit 0 in the low byte
  localparam logic [79:0] GLYPHS = {8'h09, 8'h01, 8'h2B, 8'h41, 8'h49,
                                    8'h8B, 8'h19, 8'h15, 8'hBB, 8'h21};

  localparam htfd_out_t DARK        = {{6{SEG_BLANK}}, 1'b1};
  localparam htfd_out_t UNLIT       = {{6{SEG_BLANK}}, 1'b0};
  localparam htfd_out_t TOP_SHOWN   = {8'h09, 8'h09, 8'h09, {3{SEG_BLANK}}, 1'b0};
  localparam htfd_out_t FLOOR_SHOWN = {8'h21, 8'h21, {4{SEG_BLANK}}, 1'b0};
  localparam htfd_out_t NO_RESULT   = '0;

  typedef struct packed {
    htfd_in_t  txn;
    logic      typed;
    htfd_out_t result;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  htfd_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  htfd_out_t out_data;

  logic signed [11:0] temp_now, temp_peak, temp_floor;
  logic        [9:0]  hum_now, hum_peak, hum_floor;
  logic               fault_latched;

  htfd_out_t pending_displays[$];
  row_t      directed_rows [DIR_ROWS];
  int        mismatches = 0;
  int        cycles = 0;
  bit        hold_req;
  bit        burst;

  humidity_temp_frame_to_display dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] digit_glyph(input int d);
    return GLYPHS[d*8 +: 8];
  endfunction

  function automatic void restore_extremes();
    temp_peak  = TEMP_RST_HIGH;
    temp_floor = TEMP_RST_LOW;
    hum_peak   = HUM_RST_HIGH;
    hum_floor  = HUM_RST_LOW;
  endfunction

  function automatic htfd_in_t pack_txn(input logic [1:0] op, input logic [7:0] status,
                                        input logic [19:0] raw_h, input logic [19:0] raw_t,
                                        input logic [1:0] view);
    htfd_in_t txn;
    txn.operation   = op;
    txn.status_byte = status;
    txn.frame_byte1 = raw_h[19:12];
    txn.frame_byte2 = raw_h[11:4];
    txn.frame_byte3 = {raw_h[3:0], raw_t[19:16]};
    txn.frame_byte4 = raw_t[15:8];
    txn.frame_byte5 = raw_t[7:0];
    txn.view_select = view;
    return txn;
  endfunction

  function automatic htfd_out_t predict_display(input htfd_in_t txn);
    logic [19:0] raw_h, raw_t;
    logic [63:0] scaled;
    int          t, h, m;
    htfd_out_t   res;
    raw_h = {txn.frame_byte1, txn.frame_byte2, txn.frame_byte3[7:4]};
    raw_t = {txn.frame_byte3[3:0], txn.frame_byte4, txn.frame_byte5};
    case (txn.operation)
      OP_FRAME: begin
        if ((txn.status_byte & STATUS_BUSY) != 8'd0 || (raw_h == '0 && raw_t == '0)) begin
          fault_latched = 1'b1;
        end else begin
          fault_latched = 1'b0;
          scaled = 64'(raw_t) * 64'(TEMP_SCALE);
          t = int'(scaled >> 20) - int'(TEMP_OFFSET);
          scaled = 64'(raw_h) * 64'(HUM_SCALE);
          h = int'(scaled >> 20);
          temp_now = t[11:0];
          hum_now  = h[9:0];
          if (t > int'(temp_peak)) temp_peak = t[11:0];
          if (t < int'(temp_floor)) temp_floor = t[11:0];
          if (h > int'(hum_peak)) hum_peak = h[9:0];
          if (h < int'(hum_floor)) hum_floor = h[9:0];
        end
      end
      OP_BUS_ERR: fault_latched = 1'b1;
      OP_CLEAR:   restore_extremes();
      default:    ;
    endcase

    res = DARK;
    if (!fault_latched) begin
      res.sensor_fault = 1'b0;
      if (txn.view_select == VIEW_CURRENT) begin
        t = int'(temp_now);
        h = int'(hum_now);
      end else if (txn.view_select == VIEW_HIGHEST) begin
        t = int'(temp_peak);
        h = int'(hum_peak);
      end else begin
        t = int'(temp_floor);
        h = int'(hum_floor);
      end
      if (t > int'(TEMP_SHOW_MAX) || t < int'(TEMP_SHOW_MIN)) begin
        res.digit5_segments = SEG_BLANK;
      end else if (t < 0) begin
        m = -t;
        res.digit5_segments = SEG_MINUS;
        res.digit4_segments = digit_glyph(m / 10);
        res.digit3_segments = digit_glyph(m % 10);
      end else begin
        res.digit5_segments = (t / 100 == 0) ? SEG_BLANK : digit_glyph(t / 100);
        res.digit4_segments = digit_glyph((t / 10) % 10);
        res.digit3_segments = digit_glyph(t % 10);
      end
      if (h <= int'(HUM_SHOW_MAX)) begin
        res.digit2_segments = (h / 100 == 0) ? SEG_BLANK : digit_glyph(h / 100);
        res.digit1_segments = digit_glyph((h / 10) % 10);
        res.digit0_segments = digit_glyph(h % 10);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_txn(input htfd_in_t txn, input logic typed, input htfd_out_t typed_result);
    int        gap;
    htfd_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= txn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_display(txn);
    pending_displays.push_back(typed ? typed_result : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  function automatic htfd_in_t random_txn();
    int          r, k;
    logic [1:0]  op;
    logic [7:0]  status;
    logic [19:0] raw_h, raw_t;
    r      = $urandom_range(0, 99);
    status = 8'($urandom);
    raw_h  = 20'($urandom);
    raw_t  = 20'($urandom);
    if (r < 70) begin
      op = OP_FRAME;
      status = ($urandom_range(0, 9) == 0) ? (status | STATUS_BUSY) : (status & ~STATUS_BUSY);
      k = $urandom_range(0, 19);
      if (k == 19) begin
        raw_h = '0;
        raw_t = '0;
      end else if (k >= 6) begin
        raw_t = 20'($urandom_range(RAW_T_SHOW_LO, RAW_T_SHOW_HI));
        if (k < 9) raw_h = 20'($urandom_range(0, 110000));
      end
    end else if (r < 80) begin
      op = OP_BUS_ERR;
    end else if (r < 88) begin
      op = OP_CLEAR;
    end else begin
      op = OP_REFRESH;
    end
    return pack_txn(op, status, raw_h, raw_t, 2'($urandom_range(0, 3)));
  endfunction

  initial begin
    int n, r;
    bit v;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        v = 1'b1;
        n = HOLD_CYCLES;
        held = 1'b1;
      end else if (burst) begin
        v = 1'b0;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          v = 1'b0;
          n = $urandom_range(1, 8);
        end else if (r < 92) begin
          v = 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          v = 1'b1;
          n = $urandom_range(8, 30);
        end
      end
      out_stall <= v;
      repeat (n - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : display_check
    htfd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected display transaction %h", out_data);
      end else begin
        want = pending_displays.pop_front();
        if (out_data.digit0_segments !== want.digit0_segments ||
            out_data.digit1_segments !== want.digit1_segments ||
            out_data.digit2_segments !== want.digit2_segments ||
            out_data.digit3_segments !== want.digit3_segments ||
            out_data.digit4_segments !== want.digit4_segments ||
            out_data.digit5_segments !== want.digit5_segments ||
            out_data.sensor_fault !== want.sensor_fault) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("display mismatch: expected %h %h %h %h %h %h fault %b",
                     want.digit0_segments, want.digit1_segments, want.digit2_segments,
                     want.digit3_segments, want.digit4_segments, want.digit5_segments,
                     want.sensor_fault);
            $display("                  actual   %h %h %h %h %h %h fault %b",
                     out_data.digit0_segments, out_data.digit1_segments,
                     out_data.digit2_segments, out_data.digit3_segments,
                     out_data.digit4_segments, out_data.digit5_segments,
                     out_data.sensor_fault);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    hold_req   = 1'b0;
    burst      = 1'b0;
    temp_now   = '0;
    hum_now    = '0;
    fault_latched = 1'b1;
    restore_extremes();

    directed_rows = '{
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_CURRENT), 1'b1, DARK},
      {pack_txn(OP_FRAME, STATUS_BUSY, 20'hFFFFF, 20'hFFFFF, VIEW_CURRENT), 1'b1, DARK},
      {pack_txn(OP_FRAME, 8'h00, 20'h0, 20'h0, VIEW_CURRENT), 1'b1, DARK},
      {pack_txn(OP_FRAME, 8'h00, 20'hFFFFF, 20'hFFFFF, VIEW_CURRENT), 1'b1, TOP_SHOWN},
      {pack_txn(OP_BUS_ERR, 8'h00, 20'h0, 20'h0, VIEW_CURRENT), 1'b1, DARK},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_HIGHEST), 1'b1, DARK},
      {pack_txn(OP_FRAME, 8'h7F, 20'h0, 20'h1, VIEW_CURRENT), 1'b1, FLOOR_SHOWN},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_HIGHEST), 1'b1, TOP_SHOWN},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_LOWEST), 1'b1, FLOOR_SHOWN},
      {pack_txn(OP_CLEAR, 8'h00, 20'h0, 20'h0, VIEW_LOWEST), 1'b1, UNLIT},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_HIGHEST), 1'b1, FLOOR_SHOWN},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_SPARE), 1'b1, UNLIT},
      {pack_txn(OP_FRAME, 8'h00, 20'h80000, 20'h3C000, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h00, 20'h19000, 20'h33540, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h00, 20'h00001, 20'h33334, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h1C, 20'h0A000, 20'h40000, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h00, 20'hFFF00, 20'hBFDF4, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h00, 20'h4CCCD, 20'hC0000, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_HIGHEST), 1'b0, NO_RESULT},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_LOWEST), 1'b0, NO_RESULT},
      {pack_txn(OP_CLEAR, 8'h00, 20'h0, 20'h0, VIEW_CURRENT), 1'b0, NO_RESULT},
      {pack_txn(OP_FRAME, 8'h8F, 20'h12345, 20'h6789A, VIEW_HIGHEST), 1'b1, DARK},
      {pack_txn(OP_REFRESH, 8'h00, 20'h0, 20'h0, VIEW_CURRENT), 1'b1, DARK},
      {pack_txn(OP_FRAME, 8'h00, 20'h7FFFF, 20'h55555, VIEW_SPARE), 1'b0, NO_RESULT}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_txn(directed_rows[i].txn, directed_rows[i].typed, directed_rows[i].result);
    drain_pause();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold with back-to-back input so the pipeline backs up
      if (i == 200) begin
        hold_req = 1'b1;
        burst    = 1'b1;
      end
      if (i == 230 || i == 440) burst = 1'b0;
      if (i == 400) burst = 1'b1;
      if (i == 500) drain_pause();
      send_txn(random_txn(), 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;

    while (pending_displays.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_displays.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
